>>> rtl/core/mbsp_pkg.sv
package mbsp_pkg;

  typedef enum logic [2:0] {
    CMD_STATUS = 3'd0,
    CMD_SEND   = 3'd1,
    CMD_RECV   = 3'd2,
    CMD_SET    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  localparam int WordW = 16;
  localparam int FlagW = 3;

  typedef struct packed {
    logic [WordW-1:0] read_data;
    logic [FlagW-1:0] ready_flags;
    logic             data_event;
    logic [1:0]       event_channel;
    logic             bad_channel;
  } chan_res_t;

  typedef struct packed {
    logic [WordW-1:0] semaphore_bits;
    logic             signal_level;
    logic             semaphore_event;
  } sema_res_t;

endpackage

>>> rtl/core/mbsp_chan.sv
module mbsp_chan
  import mbsp_pkg::*;
#(
  parameter int NUM_CHANNELS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             apply,
  input  cmd_t             cmd,
  input  logic [1:0]       channel,
  input  logic [WordW-1:0] value,
  output chan_res_t        res
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [WordW-1:0]        word_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ready_r;
  logic [NUM_CHANNELS-1:0] ready_nxt;
  logic [IdxW-1:0]         idx;
  logic                    ch_ok;
  logic                    is_send;
  logic                    is_recv;
  logic [FlagW-1:0]        flags;

  assign idx     = IdxW'(channel);
  assign ch_ok   = (32'(channel) < NUM_CHANNELS);
  assign is_send = (cmd == CMD_SEND);
  assign is_recv = (cmd == CMD_RECV);

  always_comb begin
    ready_nxt = ready_r;
    if (ch_ok && is_send) begin
      ready_nxt[idx] = 1'b1;
    end else if (ch_ok && is_recv) begin
      ready_nxt[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        word_r[i] <= '0;
      end
    end else if (apply) begin
      ready_r <= ready_nxt;
      if (ch_ok && is_send) begin
        word_r[idx] <= value;
      end
    end
  end

  // only the first three channels are reported
  for (genvar g = 0; g < FlagW; g++) begin : g_flag
    if (g < NUM_CHANNELS) begin : g_on
      assign flags[g] = ready_nxt[g];
    end else begin : g_off
      assign flags[g] = 1'b0;
    end
  end

  always_comb begin
    res               = '0;
    res.ready_flags   = flags;
    res.read_data     = (ch_ok && is_recv) ? word_r[idx] : '0;
    res.data_event    = ch_ok && is_send;
    res.event_channel = (ch_ok && is_send) ? channel : 2'd0;
    res.bad_channel   = !ch_ok && (is_send || is_recv);
  end

endmodule

>>> rtl/core/mbsp_sema.sv
module mbsp_sema
  import mbsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             apply,
  input  cmd_t             cmd,
  input  logic [WordW-1:0] value,
  input  logic             cfg_wr_en,
  input  logic [WordW-1:0] cfg_wr_data,
  output sema_res_t        res
);

  logic [WordW-1:0] mask_r;
  logic [WordW-1:0] sema_r;
  logic [WordW-1:0] sema_nxt;
  logic             sig_r;
  logic             sig_nxt;
  logic             sev;

  always_comb begin
    sema_nxt = sema_r;
    sig_nxt  = sig_r;
    sev      = 1'b0;
    unique case (cmd)
      CMD_SET: begin
        sema_nxt = sema_r | value;
        if (|(sema_nxt & ~mask_r)) begin
          sev     = 1'b1;
          sig_nxt = 1'b1;
        end
      end
      CMD_CLEAR: begin
        sema_nxt = sema_r & ~value;
        // recompute the signal from what is left unmasked
        sig_nxt  = |(sema_nxt & ~mask_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      sema_r <= '0;
      sig_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      if (apply) begin
        sema_r <= sema_nxt;
        sig_r  <= sig_nxt;
      end
    end
  end

  always_comb begin
    res.semaphore_bits  = sema_nxt;
    res.signal_level    = sig_nxt;
    res.semaphore_event = sev;
  end

endmodule

>>> rtl/core/mailbox_semaphore_port.sv
// Mailbox port with NUM_CHANNELS 16-bit data channels and a 16-bit semaphore.
// Input channel: in_valid/in_ready carry one item (cmd, channel, value).
// Result channel: out_valid/out_ready carry exactly one result per item,
// in order: read data, ready flags, semaphore, signal and event pulses.
// Configuration: cfg_wr_en/cfg_wr_data write the semaphore mask at once;
// write it only while no item is in flight.
// Path: an accepted item is latched in the input register, processed by the
// channel and semaphore logic, and its result is latched in the result
// register, which drives out_valid; while out_ready is low and a result is
// waiting, the item stays in the input register.
// Throughput: one item per cycle while out_ready is high; the state update
// is a single short pass between input register and result register.
// Stall: when out_ready is low the result holds, the input register holds
// one more item, and in_ready drops once both are full.
// Reset (rst_n low, synchronous): clears channel words, ready flags,
// semaphore, signal, mask and all valid bits.
module mailbox_semaphore_port
  import mbsp_pkg::*;
#(
  parameter int NUM_CHANNELS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_cmd,
  input  logic [1:0]       in_channel,
  input  logic [WordW-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_read_data,
  output logic [FlagW-1:0] out_ready_flags,
  output logic [WordW-1:0] out_semaphore_bits,
  output logic             out_signal_level,
  output logic             out_data_event,
  output logic [1:0]       out_event_channel,
  output logic             out_semaphore_event,
  output logic             out_bad_channel,
  input  logic             cfg_wr_en,
  input  logic [WordW-1:0] cfg_wr_data
);

  logic             s1_v_r;
  logic [2:0]       s1_cmd_r;
  logic [1:0]       s1_ch_r;
  logic [WordW-1:0] s1_val_r;
  logic             out_v_r;
  chan_res_t        chan_res;
  chan_res_t        chan_r;
  sema_res_t        sema_res;
  sema_res_t        sema_r;
  logic             adv;
  logic             apply;
  cmd_t             s1_cmd;

  assign adv      = !out_v_r || out_ready;
  assign apply    = s1_v_r && adv;
  assign in_ready = !s1_v_r || adv;
  assign s1_cmd   = cmd_t'(s1_cmd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= in_cmd;
      s1_ch_r  <= in_channel;
      s1_val_r <= in_value;
    end
    if (apply) begin
      chan_r <= chan_res;
      sema_r <= sema_res;
    end
  end

  mbsp_chan #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_chan (
    .clk    (clk),
    .rst_n  (rst_n),
    .apply  (apply),
    .cmd    (s1_cmd),
    .channel(s1_ch_r),
    .value  (s1_val_r),
    .res    (chan_res)
  );

  mbsp_sema u_sema (
    .clk        (clk),
    .rst_n      (rst_n),
    .apply      (apply),
    .cmd        (s1_cmd),
    .value      (s1_val_r),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .res        (sema_res)
  );

  assign out_valid           = out_v_r;
  assign out_read_data       = chan_r.read_data;
  assign out_ready_flags     = chan_r.ready_flags;
  assign out_data_event      = chan_r.data_event;
  assign out_event_channel   = chan_r.event_channel;
  assign out_bad_channel     = chan_r.bad_channel;
  assign out_semaphore_bits  = sema_r.semaphore_bits;
  assign out_signal_level    = sema_r.signal_level;
  assign out_semaphore_event = sema_r.semaphore_event;

  a_event_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data_event && out_bad_channel) &&
                  !(out_data_event && out_semaphore_event))
    else $error("data event together with another flag");

  a_sev_signal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_semaphore_event) |-> out_signal_level)
    else $error("semaphore event without signal");

  a_evch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_event) |-> (out_event_channel == 2'd0))
    else $error("event channel set without data event");

  a_evch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_event) |-> (32'(out_event_channel) < NUM_CHANNELS))
    else $error("data event on channel out of range");

  a_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("input register lost an item during stall");

endmodule
